FILE: hw/rtl/stuffed_checksum_frame_decoder_defines.svh
// ---------------------------------------------------------------------------
// Stuffed checksum frame decoder: assertion macros
// Concurrent check wrappers, compiled out for synthesis.
// ---------------------------------------------------------------------------
`ifndef STUFFED_CHECKSUM_FRAME_DECODER_DEFINES_SVH
`define STUFFED_CHECKSUM_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define SCFD_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SCFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`else
`define SCFD_ASSERT(label, clk, rst_n, prop, msg)
`define SCFD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hw/rtl/scfd_pkg.sv
// ---------------------------------------------------------------------------
// Stuffed checksum frame decoder package
// Byte codes, error codes, phases and the result record.
// ---------------------------------------------------------------------------
package scfd_pkg;

  localparam int MAX_FRAME_DEFAULT = 256;

  localparam logic [7:0] BYTE_DELIM = 8'h2E;
  localparam logic [7:0] BYTE_ESC   = 8'h2D;
  localparam logic [7:0] ESC_DELIM  = 8'hAE;
  localparam logic [7:0] ESC_ESC    = 8'hAD;
  localparam logic [7:0] SUM_GOOD   = 8'hFF;
  localparam int         HEAD_AND_CHECK = 3;

  localparam logic [7:0] MAX_LENGTH_RESET = 8'd255;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FRAME = 2'd1;
  localparam logic [1:0] PH_ESC   = 2'd2;
  localparam logic [1:0] PH_DONE  = 2'd3;

  localparam logic [2:0] ERR_OK       = 3'd0;
  localparam logic [2:0] ERR_START    = 3'd1;
  localparam logic [2:0] ERR_STUFF    = 3'd2;
  localparam logic [2:0] ERR_STOP     = 3'd3;
  localparam logic [2:0] ERR_CHECKSUM = 3'd4;
  localparam logic [2:0] ERR_LENGTH   = 3'd5;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  localparam int OUT_FIELDS_W = 35;
  localparam int OUT_TDATA_W  = 40;

  typedef struct packed {
    logic       valid;
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [2:0] error_code;
    logic [7:0] device_status;
    logic [7:0] frame_length;
  } res_t;

endpackage

FILE: hw/rtl/scfd_core.sv
// ---------------------------------------------------------------------------
// Stuffed checksum frame decoder core
// Frame state registers and the per-byte destuff, sum and verdict logic.
// ---------------------------------------------------------------------------
module scfd_core #(
  parameter int MAX_FRAME = scfd_pkg::MAX_FRAME_DEFAULT
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            take,
  input  logic [7:0]      rx_byte,
  input  logic            first,
  input  logic            last,
  input  logic [7:0]      max_length,
  output scfd_pkg::res_t  res
);

  localparam int CW = $clog2(MAX_FRAME + 1);
  localparam int WW = (CW > 8) ? CW : 8;

  logic [1:0]    phase_r,  phase_nxt;
  logic [CW-1:0] count_r,  count_nxt;
  logic [7:0]    sum_r,    sum_nxt;
  logic [7:0]    status_r, status_nxt;
  logic [7:0]    length_r, length_nxt;
  logic [7:0]    held_r,   held_nxt;

  always_comb begin
    logic [1:0]    ph;
    logic [CW-1:0] cnt;
    logic [7:0]    sum;
    logic [7:0]    sts;
    logic [7:0]    len;
    logic [7:0]    held;
    logic          dec_go;
    logic [7:0]    dec;
    logic          verdict;
    logic [2:0]    code;
    logic [7:0]    flen;
    logic [WW-1:0] cnt_w;
    logic [WW-1:0] rel_w;

    ph   = first ? scfd_pkg::PH_IDLE : phase_r;
    cnt  = first ? '0 : count_r;
    sum  = first ? '0 : sum_r;
    sts  = first ? '0 : status_r;
    len  = first ? '0 : length_r;
    held = first ? '0 : held_r;

    dec_go  = 1'b0;
    dec     = rx_byte;
    verdict = 1'b0;
    code    = scfd_pkg::ERR_OK;
    flen    = '0;
    cnt_w   = WW'(cnt);
    rel_w   = cnt_w - WW'(scfd_pkg::HEAD_AND_CHECK);

    phase_nxt  = ph;
    count_nxt  = cnt;
    sum_nxt    = sum;
    status_nxt = sts;
    length_nxt = len;
    held_nxt   = held;
    res        = '0;

    unique case (ph)
      scfd_pkg::PH_IDLE: begin
        if (rx_byte != scfd_pkg::BYTE_DELIM) begin
          verdict = 1'b1;
          code    = scfd_pkg::ERR_START;
        end else if (last) begin
          verdict = 1'b1;
          code    = scfd_pkg::ERR_STOP;
        end else begin
          phase_nxt = scfd_pkg::PH_FRAME;
        end
      end
      scfd_pkg::PH_FRAME: begin
        priority if (rx_byte == scfd_pkg::BYTE_DELIM) begin
          verdict = 1'b1;
          priority if (sum != scfd_pkg::SUM_GOOD) begin
            code = scfd_pkg::ERR_CHECKSUM;
          end else if (cnt_w > WW'(2)) begin
            if (rel_w != WW'(len)) begin
              code = scfd_pkg::ERR_LENGTH;
            end else begin
              flen = rel_w[7:0];
            end
          end else if (cnt_w == WW'(2)) begin
            flen = '0;
          end else begin
            code = scfd_pkg::ERR_LENGTH;
          end
        end else if (rx_byte == scfd_pkg::BYTE_ESC) begin
          if (last) begin
            verdict = 1'b1;
            code    = scfd_pkg::ERR_STUFF;
          end else begin
            phase_nxt = scfd_pkg::PH_ESC;
          end
        end else begin
          dec_go = 1'b1;
        end
      end
      scfd_pkg::PH_ESC: begin
        priority if (rx_byte == scfd_pkg::ESC_DELIM) begin
          dec_go = 1'b1;
          dec    = scfd_pkg::BYTE_DELIM;
        end else if (rx_byte == scfd_pkg::ESC_ESC) begin
          dec_go = 1'b1;
          dec    = scfd_pkg::BYTE_ESC;
        end else begin
          verdict = 1'b1;
          code    = scfd_pkg::ERR_STUFF;
        end
      end
      default: begin
      end
    endcase

    if (dec_go) begin
      priority if (last) begin
        verdict = 1'b1;
        code    = scfd_pkg::ERR_STOP;
      end else if (cnt_w >= WW'(MAX_FRAME)) begin
        verdict = 1'b1;
        code    = scfd_pkg::ERR_LENGTH;
      end else begin
        sum_nxt = sum + dec;
        if (cnt_w == WW'(0)) begin
          status_nxt = dec;
        end
        if (cnt_w == WW'(1)) begin
          length_nxt = dec;
        end
        if (cnt_w >= WW'(scfd_pkg::HEAD_AND_CHECK) && rel_w < WW'(max_length)) begin
          res.valid         = 1'b1;
          res.kind          = scfd_pkg::KIND_PAYLOAD;
          res.payload_byte  = held;
          res.payload_index = rel_w[7:0];
        end
        held_nxt  = dec;
        count_nxt = cnt + CW'(1);
        phase_nxt = scfd_pkg::PH_FRAME;
      end
    end

    if (verdict) begin
      phase_nxt         = scfd_pkg::PH_DONE;
      res.valid         = 1'b1;
      res.kind          = scfd_pkg::KIND_VERDICT;
      res.error_code    = code;
      res.device_status = sts;
      res.frame_length  = (code == scfd_pkg::ERR_OK) ? flen : 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= scfd_pkg::PH_IDLE;
      count_r  <= '0;
      sum_r    <= '0;
      status_r <= '0;
      length_r <= '0;
      held_r   <= '0;
    end else if (take) begin
      phase_r  <= phase_nxt;
      count_r  <= count_nxt;
      sum_r    <= sum_nxt;
      status_r <= status_nxt;
      length_r <= length_nxt;
      held_r   <= held_nxt;
    end
  end

endmodule

FILE: hw/rtl/stuffed_checksum_frame_decoder.sv
// ---------------------------------------------------------------------------
// Stuffed checksum frame decoder
// Checks start byte, undoes byte stuffing, sums the frame and emits payload
// bytes by index followed by one verdict per frame.
// ---------------------------------------------------------------------------
// A result is registered and appears on out_ in the cycle after its byte is taken.
// Throughput: one byte per cycle while in_tready is high; the frame state is registered on each taken byte.
// in_tready stays high while the output register is empty or draining.
// Reset (rst_n low, synchronous) clears frame state and output valid and
// sets max_length to 255.
`include "stuffed_checksum_frame_decoder_defines.svh"

module stuffed_checksum_frame_decoder #(
  parameter int MAX_FRAME = scfd_pkg::MAX_FRAME_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // max_length
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,      // rx_byte
  input  logic        in_tuser,      // first
  input  logic        in_tlast,      // last
  output logic        out_tvalid,
  input  logic        out_tready,
  // payload_byte[7:0], payload_index[15:8], error_code[18:16],
  // device_status[26:19], frame_length[34:27], zero pad[39:35]
  output logic [scfd_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic        out_tuser      // result_kind
);

  logic           take;
  logic [7:0]     max_length_r;
  scfd_pkg::res_t res;
  scfd_pkg::res_t out_r;
  logic           out_valid_r, out_valid_nxt;

  assign in_tready = !out_valid_r || out_tready;
  assign take      = in_tvalid && in_tready;

  scfd_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .rx_byte    (in_tdata),
    .first      (in_tuser),
    .last       (in_tlast),
    .max_length (max_length_r),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= scfd_pkg::MAX_LENGTH_RESET;
    end else if (cfg_wr_en) begin
      max_length_r <= cfg_wr_data;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (take) begin
      out_valid_nxt = res.valid;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res.valid) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_r.kind;
  assign out_tdata  = {
    (scfd_pkg::OUT_TDATA_W - scfd_pkg::OUT_FIELDS_W)'(0),
    out_r.frame_length,
    out_r.device_status,
    out_r.error_code,
    out_r.payload_index,
    out_r.payload_byte
  };

  `SCFD_ASSERT(a_result_shown, clk, rst_n, take && res.valid |=> out_tvalid,
               "result lost")
  `SCFD_ASSERT_IMPL(a_payload_clean, clk, rst_n, out_tvalid && !out_tuser,
                    out_tdata[34:16] == 19'd0, "payload result carries verdict fields")
  `SCFD_ASSERT_IMPL(a_code_range, clk, rst_n, out_tvalid && out_tuser,
                    out_tdata[18:16] <= scfd_pkg::ERR_LENGTH, "bad error code")
  `SCFD_ASSERT_IMPL(a_len_on_error, clk, rst_n,
                    out_tvalid && out_tuser && out_tdata[18:16] != scfd_pkg::ERR_OK,
                    out_tdata[34:27] == 8'd0, "frame length on failed frame")

endmodule

FILE: bench/testbench.sv
// ---------------------------------------------------------------------------
// Stuffed checksum frame decoder testbench
// Sends stuffed, checksummed frames (clean, corrupted, cut short, oversized
// and plain noise) through the byte stream, predicts payload and verdict
// results per byte, and checks every result against the prediction under
// random idling on both sides and several max_length settings.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAME_LIMIT  = scfd_pkg::MAX_FRAME_DEFAULT;
  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 8;
  localparam int REPORT_MAX   = 10;

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
  } rx_item_t;

  typedef enum int {
    FM_GOOD,
    FM_BAD_SUM,
    FM_BAD_LEN,
    FM_BAD_ESC,
    FM_TRUNCATED,
    FM_NO_FIRST,
    FM_BAD_START
  } frame_fault_t;

  logic                             clk         = 1'b0;
  logic                             rst_n       = 1'b0;
  logic                             cfg_wr_en   = 1'b0;
  logic [7:0]                       cfg_wr_data = 8'd0;
  logic                             in_tvalid   = 1'b0;
  logic [7:0]                       in_tdata    = 8'd0;
  logic                             in_tuser    = 1'b0;
  logic                             in_tlast    = 1'b0;
  logic                             out_tready  = 1'b0;
  logic                             in_tready;
  logic                             out_tvalid;
  logic [scfd_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic                             out_tuser;

  stuffed_checksum_frame_decoder #(
    .MAX_FRAME(FRAME_LIMIT)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // decoder state as predicted
  logic [1:0] fr_phase;
  int         fr_count;
  logic [7:0] fr_sum;
  logic [7:0] fr_status;
  logic [7:0] fr_length;
  logic [7:0] fr_held;
  logic [7:0] max_len_cfg;

  scfd_pkg::res_t results_due[$];
  rx_item_t       read_q[$];

  int send_idle_pct = 11;
  int recv_idle_pct = 77;
  int mismatches    = 0;
  int items_sent    = 0;
  int reads_sent    = 0;
  int payload_seen  = 0;
  int verdict_seen  = 0;
  int quiet_cycles  = 0;
  int verdict_tally[6];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no request for %0d cycles, %0d results outstanding",
                 quiet_cycles, results_due.size());
        $display("status: fail");
        $finish;
      end
    end
  end

  always @(posedge clk) begin : result_check
    scfd_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (out_tuser == scfd_pkg::KIND_VERDICT) begin
        verdict_seen++;
        if (out_tdata[18:16] < 6) verdict_tally[out_tdata[18:16]]++;
      end else begin
        payload_seen++;
      end
      if (results_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("unexpected result: kind %0d tdata %h", out_tuser, out_tdata);
      end else begin
        want = results_due.pop_front();
        if (out_tuser !== want.kind || out_tdata[7:0] !== want.payload_byte ||
            out_tdata[15:8] !== want.payload_index ||
            out_tdata[18:16] !== want.error_code ||
            out_tdata[26:19] !== want.device_status ||
            out_tdata[34:27] !== want.frame_length) begin
          mismatches++;
          if (mismatches <= REPORT_MAX) begin
            $display("mismatch exp: kind %0d byte %h idx %0d err %0d status %h len %0d",
                     want.kind, want.payload_byte, want.payload_index, want.error_code,
                     want.device_status, want.frame_length);
            $display("         got: kind %0d byte %h idx %0d err %0d status %h len %0d",
                     out_tuser, out_tdata[7:0], out_tdata[15:8], out_tdata[18:16],
                     out_tdata[26:19], out_tdata[34:27]);
          end
        end
      end
    end
  end

  task automatic clear_frame_state();
    fr_phase  = scfd_pkg::PH_IDLE;
    fr_count  = 0;
    fr_sum    = 8'd0;
    fr_status = 8'd0;
    fr_length = 8'd0;
    fr_held   = 8'd0;
  endtask

  task automatic post_verdict(input logic [2:0] code, input logic [7:0] flen);
    scfd_pkg::res_t r;
    r               = '0;
    r.valid         = 1'b1;
    r.kind          = scfd_pkg::KIND_VERDICT;
    r.error_code    = code;
    r.device_status = fr_status;
    r.frame_length  = (code == scfd_pkg::ERR_OK) ? flen : 8'd0;
    fr_phase        = scfd_pkg::PH_DONE;
    results_due.push_back(r);
  endtask

  task automatic close_frame();
    int plen;
    if (fr_sum != scfd_pkg::SUM_GOOD) begin
      post_verdict(scfd_pkg::ERR_CHECKSUM, 8'd0);
    end else if (fr_count > 2) begin
      plen = fr_count - scfd_pkg::HEAD_AND_CHECK;
      if (plen != fr_length) post_verdict(scfd_pkg::ERR_LENGTH, 8'd0);
      else post_verdict(scfd_pkg::ERR_OK, 8'(plen));
    end else if (fr_count == 2) begin
      post_verdict(scfd_pkg::ERR_OK, 8'd0);
    end else begin
      post_verdict(scfd_pkg::ERR_LENGTH, 8'd0);
    end
  endtask

  task automatic absorb_byte(input logic [7:0] d, input logic last);
    scfd_pkg::res_t r;
    if (last) begin
      post_verdict(scfd_pkg::ERR_STOP, 8'd0);
    end else if (fr_count >= FRAME_LIMIT) begin
      post_verdict(scfd_pkg::ERR_LENGTH, 8'd0);
    end else begin
      fr_sum = fr_sum + d;
      if (fr_count == 0) fr_status = d;
      else if (fr_count == 1) fr_length = d;
      // the held byte is payload once a later byte shows it is not the checksum
      if (fr_count >= scfd_pkg::HEAD_AND_CHECK &&
          (fr_count - scfd_pkg::HEAD_AND_CHECK) < max_len_cfg) begin
        r               = '0;
        r.valid         = 1'b1;
        r.kind          = scfd_pkg::KIND_PAYLOAD;
        r.payload_byte  = fr_held;
        r.payload_index = 8'(fr_count - scfd_pkg::HEAD_AND_CHECK);
        results_due.push_back(r);
      end
      fr_held  = d;
      fr_count = fr_count + 1;
      fr_phase = scfd_pkg::PH_FRAME;
    end
  endtask

  task automatic decode_rx_byte(input logic [7:0] b, input logic first, input logic last);
    if (first) clear_frame_state();
    unique case (fr_phase)
      scfd_pkg::PH_IDLE: begin
        if (b != scfd_pkg::BYTE_DELIM) post_verdict(scfd_pkg::ERR_START, 8'd0);
        else if (last) post_verdict(scfd_pkg::ERR_STOP, 8'd0);
        else fr_phase = scfd_pkg::PH_FRAME;
      end
      scfd_pkg::PH_FRAME: begin
        if (b == scfd_pkg::BYTE_DELIM) begin
          close_frame();
        end else if (b == scfd_pkg::BYTE_ESC) begin
          if (last) post_verdict(scfd_pkg::ERR_STUFF, 8'd0);
          else fr_phase = scfd_pkg::PH_ESC;
        end else begin
          absorb_byte(b, last);
        end
      end
      scfd_pkg::PH_ESC: begin
        if (b == scfd_pkg::ESC_DELIM) absorb_byte(scfd_pkg::BYTE_DELIM, last);
        else if (b == scfd_pkg::ESC_ESC) absorb_byte(scfd_pkg::BYTE_ESC, last);
        else post_verdict(scfd_pkg::ERR_STUFF, 8'd0);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_rx(input rx_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= it.data;
    in_tuser  <= it.first;
    in_tlast  <= it.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_rx_byte(it.data, it.first, it.last);
    items_sent++;
  endtask

  task automatic push_item(input logic [7:0] b, input logic first, input logic last);
    rx_item_t it;
    it.data  = b;
    it.first = first;
    it.last  = last;
    read_q.push_back(it);
  endtask

  task automatic flush_read();
    foreach (read_q[k]) send_rx(read_q[k]);
    read_q.delete();
    reads_sent++;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  task automatic set_max_length(input logic [7:0] value);
    wait_for_drain();
    repeat (4) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    max_len_cfg  = value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  function automatic logic [7:0] rand_byte();
    unique case ($urandom_range(0, 9))
      0:       return scfd_pkg::BYTE_DELIM;
      1:       return scfd_pkg::BYTE_ESC;
      2:       return scfd_pkg::ESC_DELIM;
      3:       return scfd_pkg::ESC_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic push_stuffed(input logic [7:0] d);
    if (d == scfd_pkg::BYTE_DELIM) begin
      push_item(scfd_pkg::BYTE_ESC, 1'b0, 1'b0);
      push_item(scfd_pkg::ESC_DELIM, 1'b0, 1'b0);
    end else if (d == scfd_pkg::BYTE_ESC) begin
      push_item(scfd_pkg::BYTE_ESC, 1'b0, 1'b0);
      push_item(scfd_pkg::ESC_ESC, 1'b0, 1'b0);
    end else begin
      push_item(d, 1'b0, 1'b0);
    end
  endtask

  task automatic build_frame(input frame_fault_t fault, input int plen);
    logic [7:0] dec[$];
    logic [7:0] sum;
    logic [7:0] b;
    int         esc_pos;
    int         cut;
    int         junk;
    sum = 8'd0;
    dec.push_back(rand_byte());
    if (!(plen == 0 && $urandom_range(0, 1) == 1)) begin
      b = 8'(plen);
      if (fault == FM_BAD_LEN) b = b + 8'($urandom_range(1, 9));
      dec.push_back(b);
    end
    repeat (plen) dec.push_back(rand_byte());
    foreach (dec[k]) sum = sum + dec[k];
    b = scfd_pkg::SUM_GOOD - sum;
    if (fault == FM_BAD_SUM) b = b ^ 8'($urandom_range(1, 255));
    dec.push_back(b);

    if (fault == FM_BAD_START) begin
      do b = rand_byte(); while (b == scfd_pkg::BYTE_DELIM);
    end else begin
      b = scfd_pkg::BYTE_DELIM;
    end
    push_item(b, fault != FM_NO_FIRST, 1'b0);
    esc_pos = $urandom_range(0, dec.size() - 1);
    foreach (dec[k]) begin
      if (fault == FM_BAD_ESC && k == esc_pos) begin
        push_item(scfd_pkg::BYTE_ESC, 1'b0, 1'b0);
        do b = rand_byte(); while (b == scfd_pkg::ESC_DELIM || b == scfd_pkg::ESC_ESC);
        push_item(b, 1'b0, 1'b0);
      end
      push_stuffed(dec[k]);
    end

    if (fault == FM_TRUNCATED) begin
      cut = $urandom_range(2, read_q.size());
      while (read_q.size() > cut) void'(read_q.pop_back());
      read_q[read_q.size() - 1].last = 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      push_item(scfd_pkg::BYTE_DELIM, 1'b0, 1'b0);
      junk = $urandom_range(1, 3);
      for (int k = 0; k < junk; k++) push_item(rand_byte(), 1'b0, k == junk - 1);
    end else begin
      push_item(scfd_pkg::BYTE_DELIM, 1'b0, 1'b1);
    end
  endtask

  task automatic build_noise();
    int n;
    n = $urandom_range(1, 6);
    repeat (n) push_item(rand_byte(), $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  task automatic test_directed_cases();
    // from reset the start byte needs no first flag; escaped status, empty payload
    push_item(scfd_pkg::BYTE_DELIM, 1'b0, 1'b0);
    push_item(scfd_pkg::BYTE_ESC, 1'b0, 1'b0);
    push_item(scfd_pkg::ESC_DELIM, 1'b0, 1'b0);
    push_item(8'hD1, 1'b0, 1'b0);
    push_item(scfd_pkg::BYTE_DELIM, 1'b0, 1'b1);
    flush_read();
    push_item(8'h00, 1'b1, 1'b0);                     // wrong start byte
    flush_read();
    push_item(scfd_pkg::BYTE_DELIM, 1'b1, 1'b1);      // start byte ends the read
    flush_read();
    push_item(scfd_pkg::BYTE_DELIM, 1'b1, 1'b0);      // escape without partner
    push_item(scfd_pkg::BYTE_ESC, 1'b0, 1'b1);
    flush_read();
    push_item(scfd_pkg::BYTE_DELIM, 1'b1, 1'b0);      // escape followed by delimiter
    push_item(scfd_pkg::BYTE_ESC, 1'b0, 1'b0);
    push_item(scfd_pkg::BYTE_DELIM, 1'b0, 1'b0);
    flush_read();
    push_item(scfd_pkg::BYTE_DELIM, 1'b1, 1'b0);      // read ends before stop byte
    push_item(8'hFF, 1'b0, 1'b1);
    flush_read();
    push_item(scfd_pkg::BYTE_DELIM, 1'b1, 1'b0);      // single decoded byte
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(scfd_pkg::BYTE_DELIM, 1'b0, 1'b0);
    flush_read();
    push_item(scfd_pkg::BYTE_DELIM, 1'b1, 1'b0);      // bad sum, then an ignored byte
    push_item(8'h01, 1'b0, 1'b0);
    push_item(scfd_pkg::BYTE_DELIM, 1'b0, 1'b0);
    push_item(8'hFF, 1'b0, 1'b1);
    flush_read();
    push_item(scfd_pkg::BYTE_DELIM, 1'b1, 1'b0);      // one escaped payload byte
    push_item(8'hFF, 1'b0, 1'b0);
    push_item(8'h01, 1'b0, 1'b0);
    push_item(scfd_pkg::BYTE_ESC, 1'b0, 1'b0);
    push_item(scfd_pkg::ESC_ESC, 1'b0, 1'b0);
    push_item(8'hD2, 1'b0, 1'b0);
    push_item(scfd_pkg::BYTE_DELIM, 1'b0, 1'b1);
    flush_read();
  endtask

  task automatic test_frame_size_limit();
    set_max_length(scfd_pkg::MAX_LENGTH_RESET);
    build_frame(FM_GOOD, FRAME_LIMIT - scfd_pkg::HEAD_AND_CHECK);
    flush_read();
    build_frame(FM_GOOD, $urandom_range(FRAME_LIMIT - 2, FRAME_LIMIT + 4));
    flush_read();
  endtask

  task automatic test_random_frames(input int item_goal);
    int           base;
    int           roll;
    int           plen;
    bit           paused;
    frame_fault_t fault;
    base   = items_sent;
    paused = 1'b0;
    while (items_sent - base < item_goal) begin
      roll = $urandom_range(0, 99);
      if (roll < 62) fault = FM_GOOD;
      else if (roll < 69) fault = FM_BAD_SUM;
      else if (roll < 75) fault = FM_BAD_LEN;
      else if (roll < 81) fault = FM_BAD_ESC;
      else if (roll < 87) fault = FM_TRUNCATED;
      else if (roll < 90) fault = FM_NO_FIRST;
      else if (roll < 94) fault = FM_BAD_START;
      roll = $urandom_range(0, 99);
      if (roll < 88) plen = $urandom_range(0, 12);
      else if (roll < 98) plen = $urandom_range(13, 60);
      else plen = $urandom_range(200, FRAME_LIMIT - scfd_pkg::HEAD_AND_CHECK);
      if ($urandom_range(0, 99) >= 94) build_noise();
      else build_frame(fault, plen);
      flush_read();
      if (!paused && items_sent - base >= item_goal / 2) begin
        wait_for_drain();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    foreach (verdict_tally[k]) verdict_tally[k] = 0;
    max_len_cfg = scfd_pkg::MAX_LENGTH_RESET;
    clear_frame_state();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_frame_size_limit();

    set_max_length(8'($urandom_range(1, 254)));
    test_random_frames(350);

    send_idle_pct = 77;
    recv_idle_pct = 11;
    set_max_length(8'd0);
    test_random_frames(175);
    set_max_length(8'd4);
    test_random_frames(175);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_max_length(scfd_pkg::MAX_LENGTH_RESET);
    test_random_frames(350);

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d reads (%0d bytes): %0d payload results, %0d verdicts checked",
             reads_sent, items_sent, payload_seen, verdict_seen);
    $display("verdicts ok %0d start %0d stuffing %0d stop %0d checksum %0d length %0d",
             verdict_tally[scfd_pkg::ERR_OK], verdict_tally[scfd_pkg::ERR_START],
             verdict_tally[scfd_pkg::ERR_STUFF], verdict_tally[scfd_pkg::ERR_STOP],
             verdict_tally[scfd_pkg::ERR_CHECKSUM], verdict_tally[scfd_pkg::ERR_LENGTH]);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: stuffed_checksum_frame_decoder.f
+incdir+hw/rtl
hw/rtl/scfd_pkg.sv
hw/rtl/scfd_core.sv
hw/rtl/stuffed_checksum_frame_decoder.sv
bench/testbench.sv
